// ===== rtl/hbt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and constants for the heated-bed bang-bang thermostat.
// ----------------------------------------------------------------------------
package hbt_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int NOW_W    = 32;
    localparam int TEMP_W   = 14;
    localparam int TARGET_W = 7;
    localparam int SEC_W    = 16;
    localparam int SEL_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TARGET_W;

    // Default time counter width
    localparam int TIME_BITS_DEF = 32;

    // Timing periods in ms
    localparam int CONTROL_PERIOD_MS = 600;
    localparam int BEEP_PERIOD_MS    = 5000;
    localparam int COUNT_PERIOD_MS   = 1000;

    // Hysteresis in Q10.4 (2.0 C and 1.0 C)
    localparam int HYST_OFF_Q4 = 32;
    localparam int HYST_ON_Q4  = 16;

    // Fallback targets without a display, per sensor
    localparam logic [TARGET_W-1:0] FALLBACK_A = 7'd40;
    localparam logic [TARGET_W-1:0] FALLBACK_B = 7'd60;
    localparam logic [TARGET_W-1:0] FALLBACK_C = 7'd80;

    // Reset values of the configuration registers
    localparam logic [TARGET_W-1:0] TARGET_RESET  = 7'd60;
    localparam logic                DISPLAY_RESET = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY = 1'b1;

    // Sensor select codes
    localparam logic [SEL_W-1:0] SENSOR_A    = 2'd0;
    localparam logic [SEL_W-1:0] SENSOR_B    = 2'd1;
    localparam logic [SEL_W-1:0] SENSOR_C    = 2'd2;
    localparam logic [SEL_W-1:0] SENSOR_NONE = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_POLL  = 2'd0,
        KIND_ON    = 2'd1,
        KIND_OFF   = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    // Sensor selection result
    typedef struct packed {
        logic                     present;
        logic [SEL_W-1:0]         active;
        logic signed [TEMP_W-1:0] temp;
        logic [TARGET_W-1:0]      target;
    } t_sel;

    // One result item
    typedef struct packed {
        logic             heater;
        logic             beep;
        logic             enable;
        logic [SEC_W-1:0] seconds;
        logic [SEL_W-1:0] active;
    } t_result;

endpackage

// ===== rtl/hbt_sensor_sel.sv =====
// ----------------------------------------------------------------------------
// hbt_sensor_sel
// Picks the first present thermistor and works out the control target.
// ----------------------------------------------------------------------------
module hbt_sensor_sel
    import hbt_pkg::*;
(
    input  logic signed [TEMP_W-1:0] i_sensor_a_temp,
    input  logic signed [TEMP_W-1:0] i_sensor_b_temp,
    input  logic signed [TEMP_W-1:0] i_sensor_c_temp,
    input  logic [TARGET_W-1:0]      i_target,
    input  logic                     i_display,
    output t_sel                     o_sel
);

    logic [TARGET_W-1:0] w_fallback;

    always_comb begin
        o_sel = '0;
        if (i_sensor_a_temp != '0) begin
            o_sel.active = SENSOR_A;
            o_sel.temp   = i_sensor_a_temp;
        end else if (i_sensor_b_temp != '0) begin
            o_sel.active = SENSOR_B;
            o_sel.temp   = i_sensor_b_temp;
        end else if (i_sensor_c_temp != '0) begin
            o_sel.active = SENSOR_C;
            o_sel.temp   = i_sensor_c_temp;
        end else begin
            o_sel.active = SENSOR_NONE;
            o_sel.temp   = '0;
        end
        o_sel.present = (o_sel.active != SENSOR_NONE);

        case (o_sel.active)
            SENSOR_A: w_fallback = FALLBACK_A;
            SENSOR_B: w_fallback = FALLBACK_B;
            SENSOR_C: w_fallback = FALLBACK_C;
            default:  w_fallback = '0;
        endcase

        // no sensor: target 0 forces the pin low
        o_sel.target = !o_sel.present ? '0 :
                       (i_display ? i_target : w_fallback);
    end

endmodule

// ===== rtl/hbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbt_ctrl
// Thermostat state: heater level, enable flag, timers and on-time counter.
// ----------------------------------------------------------------------------
module hbt_ctrl
    import hbt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  t_kind                i_kind,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_sel                 i_sel,
    input  logic                 i_display,
    output t_result              o_res
);

    logic                 r_heater, n_heater;
    logic                 r_enable, n_enable;
    logic [TIME_BITS-1:0] r_last_ctrl, n_last_ctrl;
    logic [TIME_BITS-1:0] r_last_beep, n_last_beep;
    logic [TIME_BITS-1:0] r_last_count, n_last_count;
    logic [SEC_W-1:0]     r_seconds, n_seconds;

    logic [TIME_BITS-1:0] w_ctrl_due_at;
    logic [TIME_BITS-1:0] w_beep_due_at;
    logic [TIME_BITS-1:0] w_count_due_at;
    logic signed [15:0]   w_temp_ext;
    logic signed [15:0]   w_t16;
    logic                 w_hit_off;
    logic                 w_hit_on;
    logic                 w_beep;

    // wrapped deadlines, compared unsigned
    assign w_ctrl_due_at  = r_last_ctrl  + TIME_BITS'(CONTROL_PERIOD_MS);
    assign w_beep_due_at  = r_last_beep  + TIME_BITS'(BEEP_PERIOD_MS);
    assign w_count_due_at = r_last_count + TIME_BITS'(COUNT_PERIOD_MS);

    // hysteresis compares in Q10.4
    assign w_temp_ext = {{(16-TEMP_W){i_sel.temp[TEMP_W-1]}}, i_sel.temp};
    assign w_t16      = {{(16-TARGET_W-4){1'b0}}, i_sel.target, 4'b0000};
    assign w_hit_off  = (w_temp_ext + 16'(HYST_OFF_Q4)) >= w_t16;
    assign w_hit_on   = (w_temp_ext + 16'(HYST_ON_Q4)) <= w_t16;

    always_comb begin
        n_heater     = r_heater;
        n_enable     = r_enable;
        n_last_ctrl  = r_last_ctrl;
        n_last_beep  = r_last_beep;
        n_last_count = r_last_count;
        n_seconds    = r_seconds;
        w_beep       = 1'b0;
        unique case (i_kind)
            KIND_ON: begin
                n_last_count = i_now;
                n_enable     = 1'b1;
            end
            KIND_OFF: begin
                n_heater = 1'b0;
                n_enable = 1'b0;
            end
            KIND_CLEAR: begin
                n_seconds = '0;
            end
            KIND_POLL: begin
                if (!i_sel.present && r_enable && (i_now >= w_beep_due_at)) begin
                    n_last_beep = i_now;
                    w_beep      = 1'b1;
                end
                if ((!i_display || r_enable) && (i_now > w_ctrl_due_at)) begin
                    if (i_sel.target != '0) begin
                        if (r_heater) begin
                            if (w_hit_off) n_heater = 1'b0;
                        end else begin
                            if (w_hit_on) n_heater = 1'b1;
                        end
                    end else begin
                        n_heater = 1'b0;
                    end
                    n_last_ctrl = i_now;
                end
                if (r_enable && (i_now >= w_count_due_at)) begin
                    n_last_count = i_now;
                    n_seconds    = r_seconds + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.heater  = n_heater;
        o_res.beep    = w_beep;
        o_res.enable  = n_enable;
        o_res.seconds = n_seconds;
        o_res.active  = (i_kind == KIND_POLL) ? i_sel.active : SENSOR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heater     <= 1'b0;
            r_enable     <= 1'b0;
            r_last_ctrl  <= '0;
            r_last_beep  <= '0;
            r_last_count <= '0;
            r_seconds    <= '0;
        end else if (i_step) begin
            r_heater     <= n_heater;
            r_enable     <= n_enable;
            r_last_ctrl  <= n_last_ctrl;
            r_last_beep  <= n_last_beep;
            r_last_count <= n_last_count;
            r_seconds    <= n_seconds;
        end
    end

endmodule

// ===== rtl/heatbed_bang_bang_thermostat_unit.sv =====
// ----------------------------------------------------------------------------
// heatbed_bang_bang_thermostat_unit
// Result path: an accepted input transaction is captured in the input
//   register, then its result in the result register; one result
//   transaction per input.
// Throughput: one transaction per cycle unless the result channel stalls,
//   set by the single state update between input and result registers.
// Reset (synchronous, active low): pipeline empty, heater off, heating
//   disabled, timers and on-time zero, target 60 C, display present.
// ----------------------------------------------------------------------------
module heatbed_bang_bang_thermostat_unit
    import hbt_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,

    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [KIND_W-1:0]        i_kind,
    input  logic [NOW_W-1:0]         i_now_ms,
    input  logic signed [TEMP_W-1:0] i_sensor_a_temp,
    input  logic signed [TEMP_W-1:0] i_sensor_b_temp,
    input  logic signed [TEMP_W-1:0] i_sensor_c_temp,

    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_heater_drive,
    output logic                     o_beep_pulse,
    output logic                     o_heating_enabled,
    output logic [SEC_W-1:0]         o_on_seconds,
    output logic [SEL_W-1:0]         o_active_sensor
);

    // ---------------- configuration registers ----------------
    logic [TARGET_W-1:0] r_target;
    logic                r_display;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= TARGET_RESET;
            r_display <= DISPLAY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TARGET:  r_target  <= i_cfg_data[TARGET_W-1:0];
                REG_DISPLAY: r_display <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- input register ----------------
    // Holds one accepted transaction. It advances into the result register
    // whenever that register is empty or being drained, so the input side
    // keeps taking a transaction every cycle while results flow.
    logic                     r_in_valid;
    t_kind                    r_in_kind;
    logic [TIME_BITS-1:0]     r_in_now;
    logic signed [TEMP_W-1:0] r_in_a;
    logic signed [TEMP_W-1:0] r_in_b;
    logic signed [TEMP_W-1:0] r_in_c;

    logic    r_out_valid;
    t_result r_out;
    logic    w_advance;
    logic    w_accept;

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind <= t_kind'(i_kind);
            r_in_now  <= TIME_BITS'(i_now_ms);   // masked or widened to timer width
            r_in_a    <= i_sensor_a_temp;
            r_in_b    <= i_sensor_b_temp;
            r_in_c    <= i_sensor_c_temp;
        end
    end

    // ---------------- single-pass step logic ----------------
    t_sel    w_sel;
    t_result w_res;

    hbt_sensor_sel u_sensor_sel (
        .i_sensor_a_temp (r_in_a),
        .i_sensor_b_temp (r_in_b),
        .i_sensor_c_temp (r_in_c),
        .i_target        (r_target),
        .i_display       (r_display),
        .o_sel           (w_sel)
    );

    // thermostat state commits on the same edge the result is registered,
    // which keeps results in transaction order
    hbt_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_advance),
        .i_kind    (r_in_kind),
        .i_now     (r_in_now),
        .i_sel     (w_sel),
        .i_display (r_display),
        .o_res     (w_res)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_heater_drive    = r_out.heater;
    assign o_beep_pulse      = r_out.beep;
    assign o_heating_enabled = r_out.enable;
    assign o_on_seconds      = r_out.seconds;
    assign o_active_sensor   = r_out.active;

endmodule
